[rtl/xcrc_pkg.sv]
`default_nettype none

package xcrc_pkg;

    localparam int SHORT_PAYLOAD = 128;
    localparam int LONG_PAYLOAD  = 1024;
    localparam int COUNT_W       = $clog2(LONG_PAYLOAD);
    localparam int BLOCK_W       = 32;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // protocol characters
    localparam logic [7:0] CH_SOH  = 8'h01;
    localparam logic [7:0] CH_STX  = 8'h02;
    localparam logic [7:0] CH_ETX  = 8'h03;
    localparam logic [7:0] CH_EOT  = 8'h04;
    localparam logic [7:0] CH_ACK  = 8'h06;
    localparam logic [7:0] CH_NAK  = 8'h15;
    localparam logic [7:0] CH_CAN  = 8'h18;
    localparam logic [7:0] CH_WANT = 8'h43;

    localparam logic [7:0] NUM_SUM = 8'hFF;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_NUM  = 3'd1,
        PH_CMP  = 3'd2,
        PH_DATA = 3'd3,
        PH_CRCH = 3'd4,
        PH_CRCL = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        EV_BUSY   = 3'd0,
        EV_WAIT   = 3'd1,
        EV_ACCEPT = 3'd2,
        EV_HEADER = 3'd3,
        EV_NUMBER = 3'd4,
        EV_CRC    = 3'd5,
        EV_CANCEL = 3'd6,
        EV_END    = 3'd7
    } event_t;

endpackage

`default_nettype wire

[rtl/xcrc_crc_step.sv]
`default_nettype none

module xcrc_crc_step (
    input  wire logic [15:0] crc_in,
    input  wire logic [7:0]  data_in,
    output logic      [15:0] crc_out
);
    import xcrc_pkg::*;

    // msb-first crc-16 update over one byte
    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {data_in, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

[rtl/xmodem_crc_receiver.sv]
`default_nettype none

// channel  direction  handshake              payload
// in       input      in_valid / in_stall    op, rx_byte
// out      output     out_valid / out_stall  tx_valid, tx_byte, data_valid, data_byte,
//                                            data_offset, event_res, first_packet, block_count
//
// one beat in gives one beat out, in the cycle after it is accepted; a beat can enter every cycle while in_stall is low
// the protocol state and the result register are both written at the accepting edge
// in_stall follows out_stall only while the result register holds an untaken beat
// reset returns to idle with packet number and block count at 1

module xmodem_crc_receiver (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       op,
    input  wire logic [7:0]                 rx_byte,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            tx_valid,
    output logic [7:0]                      tx_byte,
    output logic                            data_valid,
    output logic [7:0]                      data_byte,
    output logic [xcrc_pkg::COUNT_W-1:0]    data_offset,
    output logic [2:0]                      event_res,
    output logic                            first_packet,
    output logic [xcrc_pkg::BLOCK_W-1:0]    block_count
);
    import xcrc_pkg::*;

    phase_t               phase_reg, phase_next;
    logic                 long_packet_reg, long_packet_next;
    logic [COUNT_W-1:0]   byte_count_reg, byte_count_next;
    logic [15:0]          running_crc_reg, running_crc_next;
    logic [7:0]           number_byte_reg, number_byte_next;
    logic [7:0]           complement_byte_reg, complement_byte_next;
    logic [7:0]           crc_high_byte_reg, crc_high_byte_next;
    logic [7:0]           expected_number_reg, expected_number_next;
    logic [BLOCK_W-1:0]   block_number_reg, block_number_next;
    logic                 first_seen_reg, first_seen_next;

    logic                 out_valid_reg;
    logic                 tx_valid_reg, tx_valid_next;
    logic [7:0]           tx_byte_reg, tx_byte_next;
    logic                 data_valid_reg, data_valid_next;
    logic [7:0]           data_byte_reg, data_byte_next;
    logic [COUNT_W-1:0]   data_offset_reg, data_offset_next;
    event_t               event_reg, event_next;
    logic                 first_packet_reg, first_packet_next;

    logic                 in_fire;
    logic [15:0]          crc_fed;
    logic [COUNT_W-1:0]   last_offset;
    logic [15:0]          got_crc;
    logic [7:0]           num_sum;

    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;

    xcrc_crc_step u_crc (
        .crc_in  (running_crc_reg),
        .data_in (rx_byte),
        .crc_out (crc_fed)
    );

    assign last_offset = long_packet_reg ? COUNT_W'(LONG_PAYLOAD - 1)
                                         : COUNT_W'(SHORT_PAYLOAD - 1);
    assign got_crc     = {crc_high_byte_reg, rx_byte};
    assign num_sum     = number_byte_reg + complement_byte_reg;

    always_comb
    begin
        phase_next           = phase_reg;
        long_packet_next     = long_packet_reg;
        byte_count_next      = byte_count_reg;
        running_crc_next     = running_crc_reg;
        number_byte_next     = number_byte_reg;
        complement_byte_next = complement_byte_reg;
        crc_high_byte_next   = crc_high_byte_reg;
        expected_number_next = expected_number_reg;
        block_number_next    = block_number_reg;
        first_seen_next      = first_seen_reg;

        tx_valid_next     = 1'b0;
        tx_byte_next      = 8'h00;
        data_valid_next   = 1'b0;
        data_byte_next    = 8'h00;
        data_offset_next  = '0;
        event_next        = EV_BUSY;
        first_packet_next = 1'b0;

        unique case (phase_reg)
            PH_NUM:
            begin
                if (op == OP_BYTE)
                begin
                    number_byte_next = rx_byte;
                    phase_next       = PH_CMP;
                end
            end
            PH_CMP:
            begin
                if (op == OP_BYTE)
                begin
                    complement_byte_next = rx_byte;
                    phase_next           = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (op == OP_BYTE)
                begin
                    data_valid_next  = 1'b1;
                    data_byte_next   = rx_byte;
                    data_offset_next = byte_count_reg;
                    running_crc_next = crc_fed;
                    if (byte_count_reg >= last_offset)
                    begin
                        byte_count_next = '0;
                        phase_next      = PH_CRCH;
                    end
                    else
                    begin
                        byte_count_next = byte_count_reg + COUNT_W'(1);
                    end
                end
            end
            PH_CRCH:
            begin
                if (op == OP_BYTE)
                begin
                    crc_high_byte_next = rx_byte;
                    phase_next         = PH_CRCL;
                end
            end
            PH_CRCL:
            begin
                if (op == OP_BYTE)
                begin
                    tx_valid_next = 1'b1;
                    tx_byte_next  = CH_NAK;
                    // complement first, then crc, then sequence
                    priority if (num_sum != NUM_SUM)
                    begin
                        event_next = EV_NUMBER;
                    end
                    else if (got_crc != running_crc_reg)
                    begin
                        event_next = EV_CRC;
                    end
                    else if (number_byte_reg != expected_number_reg)
                    begin
                        event_next = EV_NUMBER;
                    end
                    else
                    begin
                        first_packet_next    = !first_seen_reg;
                        first_seen_next      = 1'b1;
                        block_number_next    = block_number_reg + BLOCK_W'(1);
                        expected_number_next = expected_number_reg + 8'd1;
                        tx_byte_next         = CH_ACK;
                        event_next           = EV_ACCEPT;
                    end
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                priority if (op == OP_TICK)
                begin
                    tx_valid_next = 1'b1;
                    tx_byte_next  = CH_WANT;
                    event_next    = EV_WAIT;
                end
                else if (rx_byte == CH_CAN ||
                         (block_number_reg == BLOCK_W'(1) && rx_byte == CH_ETX))
                begin
                    first_seen_next      = 1'b0;
                    expected_number_next = 8'd1;
                    block_number_next    = BLOCK_W'(1);
                    event_next           = EV_CANCEL;
                end
                else if (rx_byte == CH_EOT)
                begin
                    tx_valid_next        = 1'b1;
                    tx_byte_next         = CH_ACK;
                    first_seen_next      = 1'b0;
                    expected_number_next = 8'd1;
                    event_next           = EV_END;
                end
                else if (rx_byte == CH_SOH || rx_byte == CH_STX)
                begin
                    long_packet_next = (rx_byte == CH_STX);
                    byte_count_next  = '0;
                    running_crc_next = 16'h0000;
                    phase_next       = PH_NUM;
                end
                else
                begin
                    tx_valid_next = 1'b1;
                    tx_byte_next  = CH_NAK;
                    event_next    = EV_HEADER;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            long_packet_reg     <= 1'b0;
            byte_count_reg      <= '0;
            running_crc_reg     <= 16'h0000;
            expected_number_reg <= 8'd1;
            block_number_reg    <= BLOCK_W'(1);
            first_seen_reg      <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg           <= phase_next;
                long_packet_reg     <= long_packet_next;
                byte_count_reg      <= byte_count_next;
                running_crc_reg     <= running_crc_next;
                expected_number_reg <= expected_number_next;
                block_number_reg    <= block_number_next;
                first_seen_reg      <= first_seen_next;
                out_valid_reg       <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // header and trailer bytes are always written before they are read
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            number_byte_reg     <= number_byte_next;
            complement_byte_reg <= complement_byte_next;
            crc_high_byte_reg   <= crc_high_byte_next;
            tx_valid_reg        <= tx_valid_next;
            tx_byte_reg         <= tx_byte_next;
            data_valid_reg      <= data_valid_next;
            data_byte_reg       <= data_byte_next;
            data_offset_reg     <= data_offset_next;
            event_reg           <= event_next;
            first_packet_reg    <= first_packet_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign tx_valid     = tx_valid_reg;
    assign tx_byte      = tx_byte_reg;
    assign data_valid   = data_valid_reg;
    assign data_byte    = data_byte_reg;
    assign data_offset  = data_offset_reg;
    assign event_res    = event_reg;
    assign first_packet = first_packet_reg;
    assign block_count  = block_number_reg;

endmodule

`default_nettype wire

[tb/xmodem_crc_receiver_test.sv]
`timescale 1ns / 1ps

module xmodem_crc_receiver_test;

    import xcrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_BEATS     = 950;
    localparam int MAX_REPORTS    = 100;

    localparam logic [7:0] CONTROL_CHARS [8] = '{
        CH_SOH, CH_STX, CH_ETX, CH_EOT, CH_ACK, CH_NAK, CH_CAN, CH_WANT
    };

    typedef struct packed {
        logic                tx_valid;
        logic [7:0]          tx_byte;
        logic                data_valid;
        logic [7:0]          data_byte;
        logic [COUNT_W-1:0]  data_offset;
        event_t              event_res;
        logic                first_packet;
        logic [BLOCK_W-1:0]  block_count;
    } reply_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_COMPLEMENT,
        FLAW_CRC,
        FLAW_NUMBER,
        FLAW_SHORTED
    } flaw_t;

    class reply_tracker;
        phase_t              rx_phase;
        logic                long_frame;
        logic [COUNT_W-1:0]  payload_index;
        logic [15:0]         crc_acc;
        logic [7:0]          block_no_byte;
        logic [7:0]          block_no_inv;
        logic [7:0]          crc_hi;
        logic [7:0]          expected_number;
        logic [BLOCK_W-1:0]  block_no;
        logic                got_first;
        reply_t              replies_due[$];
        int                  mismatches;
        int                  beats_taken;
        int                  replies_checked;
        int                  long_accepted;
        int                  event_tally[8];

        function new();
            rx_phase        = PH_IDLE;
            long_frame      = 1'b0;
            payload_index   = '0;
            crc_acc         = '0;
            block_no_byte   = '0;
            block_no_inv    = '0;
            crc_hi          = '0;
            expected_number = 8'd1;
            block_no        = 1;
            got_first       = 1'b0;
            mismatches      = 0;
            beats_taken     = 0;
            replies_checked = 0;
            long_accepted   = 0;
            foreach (event_tally[i])
                event_tally[i] = 0;
        endfunction

        // crc-16 msb first, poly 0x1021, zero init
        static function logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
            logic [15:0] c;
            c = crc ^ {b, 8'h00};
            for (int k = 0; k < 8; k++)
                c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            return c;
        endfunction

        function void take_beat(input logic beat_op, input logic [7:0] b);
            reply_t r;
            logic [15:0] got;
            r = '0;
            beats_taken++;
            if (rx_phase != PH_IDLE) begin
                // ticks inside a packet are swallowed
                if (beat_op == OP_BYTE) begin
                    case (rx_phase)
                        PH_NUM:
                        begin
                            block_no_byte = b;
                            rx_phase = PH_CMP;
                        end
                        PH_CMP:
                        begin
                            block_no_inv = b;
                            rx_phase = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            r.data_valid  = 1'b1;
                            r.data_byte   = b;
                            r.data_offset = payload_index;
                            crc_acc = crc_step(crc_acc, b);
                            if (int'(payload_index) >=
                                (long_frame ? LONG_PAYLOAD : SHORT_PAYLOAD) - 1)
                            begin
                                payload_index = '0;
                                rx_phase = PH_CRCH;
                            end
                            else
                                payload_index = payload_index + COUNT_W'(1);
                        end
                        PH_CRCH:
                        begin
                            crc_hi = b;
                            rx_phase = PH_CRCL;
                        end
                        default:
                        begin
                            got = {crc_hi, b};
                            r.tx_valid = 1'b1;
                            r.tx_byte  = CH_NAK;
                            if ({1'b0, block_no_byte} + {1'b0, block_no_inv} != {1'b0, NUM_SUM})
                                r.event_res = EV_NUMBER;
                            else if (got != crc_acc)
                                r.event_res = EV_CRC;
                            else if (block_no_byte != expected_number)
                                r.event_res = EV_NUMBER;
                            else
                            begin
                                r.first_packet  = !got_first;
                                got_first       = 1'b1;
                                block_no        = block_no + 1;
                                expected_number = expected_number + 8'd1;
                                r.tx_byte       = CH_ACK;
                                r.event_res     = EV_ACCEPT;
                                if (long_frame)
                                    long_accepted++;
                            end
                            rx_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            else if (beat_op == OP_TICK) begin
                r.tx_valid  = 1'b1;
                r.tx_byte   = CH_WANT;
                r.event_res = EV_WAIT;
            end
            else if (b == CH_CAN || (block_no == 1 && b == CH_ETX)) begin
                got_first       = 1'b0;
                expected_number = 8'd1;
                block_no        = 1;
                r.event_res     = EV_CANCEL;
            end
            else if (b == CH_EOT) begin
                r.tx_valid      = 1'b1;
                r.tx_byte       = CH_ACK;
                got_first       = 1'b0;
                expected_number = 8'd1;
                r.event_res     = EV_END;
            end
            else if (b == CH_SOH || b == CH_STX) begin
                long_frame    = (b == CH_STX);
                payload_index = '0;
                crc_acc       = '0;
                rx_phase      = PH_NUM;
            end
            else begin
                r.tx_valid  = 1'b1;
                r.tx_byte   = CH_NAK;
                r.event_res = EV_HEADER;
            end
            r.block_count = block_no;
            replies_due.push_back(r);
        endfunction

        function void check_field(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_reply(input reply_t got);
            reply_t want;
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: reply with none pending, expected nothing actual %0h",
                             $time, got);
                return;
            end
            want = replies_due.pop_front();
            replies_checked++;
            event_tally[want.event_res]++;
            check_field("tx_valid", want.tx_valid, got.tx_valid);
            check_field("tx_byte", want.tx_byte, got.tx_byte);
            check_field("data_valid", want.data_valid, got.data_valid);
            check_field("data_byte", want.data_byte, got.data_byte);
            check_field("data_offset", want.data_offset, got.data_offset);
            check_field("event_res", want.event_res, got.event_res);
            check_field("first_packet", want.first_packet, got.first_packet);
            check_field("block_count", want.block_count, got.block_count);
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                op;
    logic [7:0]          rx_byte;
    logic                out_valid;
    logic                out_stall;
    logic                tx_valid;
    logic [7:0]          tx_byte;
    logic                data_valid;
    logic [7:0]          data_byte;
    logic [COUNT_W-1:0]  data_offset;
    logic [2:0]          event_res;
    logic                first_packet;
    logic [BLOCK_W-1:0]  block_count;

    reply_t        observed;
    reply_tracker  tracker;
    logic          calm;
    int            stall_left;
    int            idle_cycles;
    int            beats_sent;

    xmodem_crc_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tx_valid     (tx_valid),
        .tx_byte      (tx_byte),
        .data_valid   (data_valid),
        .data_byte    (data_byte),
        .data_offset  (data_offset),
        .event_res    (event_res),
        .first_packet (first_packet),
        .block_count  (block_count)
    );

    assign observed = {tx_valid, tx_byte, data_valid, data_byte, data_offset,
                       event_res, first_packet, block_count};

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [7:0] pick_byte(input int control_one_in);
        if ($urandom_range(1, control_one_in) == 1)
            return CONTROL_CHARS[$urandom_range(0, 7)];
        return 8'($urandom);
    endfunction

    // random receiver back-pressure
    initial
    begin
        out_stall  = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall  = 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles = 0;
        else
        begin
            if (in_valid && !in_stall)
                tracker.take_beat(op, rx_byte);
            if (out_valid && !out_stall)
                tracker.check_reply(observed);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic push_item(input logic item_op, input logic [7:0] item_byte);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            op       = 1'($urandom);
            rx_byte  = 8'($urandom);
        end
        @(negedge clk);
        in_valid = 1'b1;
        op       = item_op;
        rx_byte  = item_byte;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
    endtask

    task automatic send_packet(input bit is_long, input flaw_t flaw);
        logic [7:0]  frame[$];
        logic [7:0]  num;
        logic [7:0]  b;
        logic [15:0] crc;
        int          len;
        int          cut;
        // the header goes first so the tracker has seen every earlier trailer
        push_item(OP_BYTE, is_long ? CH_STX : CH_SOH);
        len = is_long ? LONG_PAYLOAD : SHORT_PAYLOAD;
        num = tracker.expected_number;
        if (flaw == FLAW_NUMBER)
            num = ($urandom_range(0, 1) == 0) ? num - 8'd1 : num + 8'($urandom_range(1, 255));
        frame.push_back(num);
        frame.push_back((flaw == FLAW_COMPLEMENT) ? ~num ^ 8'($urandom_range(1, 255)) : ~num);
        crc = '0;
        repeat (len)
        begin
            b = pick_byte(10);
            crc = reply_tracker::crc_step(crc, b);
            frame.push_back(b);
        end
        if (flaw == FLAW_CRC)
            crc ^= 16'($urandom_range(1, 65535));
        frame.push_back(crc[15:8]);
        frame.push_back(crc[7:0]);
        // a cut-off packet lets the next sequence land inside its frame
        cut = (flaw == FLAW_SHORTED) ? $urandom_range(0, frame.size() - 1) : frame.size();
        for (int i = 0; i < cut; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                push_item(OP_TICK, 8'($urandom));
            push_item(OP_BYTE, frame[i]);
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n)
        begin
            if ($urandom_range(0, 3) == 0)
                push_item(OP_TICK, 8'($urandom));
            else
                push_item(OP_BYTE, pick_byte(2));
        end
    endtask

    initial
    begin
        int    r;
        bit    is_long;
        flaw_t flaw;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op         = OP_BYTE;
        rx_byte    = 8'h00;
        calm       = 1'b0;
        beats_sent = 0;
        tracker    = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // idle-state cases
        push_item(OP_TICK, 8'hFF);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'hFF);
        push_item(OP_BYTE, 8'h80);
        push_item(OP_BYTE, 8'h7F);
        push_item(OP_BYTE, CH_ACK);
        push_item(OP_BYTE, CH_NAK);
        push_item(OP_BYTE, CH_WANT);
        push_item(OP_BYTE, CH_ETX);
        push_item(OP_BYTE, CH_CAN);
        push_item(OP_BYTE, CH_EOT);
        push_item(OP_TICK, 8'h00);
        push_item(OP_BYTE, CH_ETX);

        send_packet(1'b0, FLAW_NONE);
        send_packet(1'b0, FLAW_NUMBER);

        while (beats_sent < ITEM_BEATS)
        begin
            is_long = 1'b0;
            if ($urandom_range(0, 14) == 0)
                calm = !calm;
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                is_long = ($urandom_range(0, 19) == 0);
                if (r < 50)
                    flaw = FLAW_NONE;
                else if (r < 58)
                    flaw = FLAW_COMPLEMENT;
                else if (r < 66)
                    flaw = FLAW_CRC;
                else if (r < 74)
                    flaw = FLAW_NUMBER;
                else
                    flaw = FLAW_SHORTED;
                send_packet(is_long, flaw);
            end
            else if (r < 90)
                send_noise();
            else if (r < 94)
                push_item(OP_BYTE, CH_EOT);
            else if (r < 97)
                push_item(OP_BYTE, CH_CAN);
            else
                push_item(OP_BYTE, CH_ETX);
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.replies_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("drove %0d beats, checked %0d replies, %0d packets accepted (%0d long)",
                 tracker.beats_taken, tracker.replies_checked,
                 tracker.event_tally[EV_ACCEPT], tracker.long_accepted);
        $display("bad header %0d, bad number %0d, bad crc %0d, cancel %0d, end %0d, wait %0d",
                 tracker.event_tally[EV_HEADER], tracker.event_tally[EV_NUMBER],
                 tracker.event_tally[EV_CRC], tracker.event_tally[EV_CANCEL],
                 tracker.event_tally[EV_END], tracker.event_tally[EV_WAIT]);
        if (tracker.mismatches == 0 && tracker.replies_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/xcrc_pkg.sv
rtl/xcrc_crc_step.sv
rtl/xmodem_crc_receiver.sv
tb/xmodem_crc_receiver_test.sv
